// ===== src/bdpc_pkg.sv =====
package bdpc_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned KIND_W = 2;

	localparam logic [IDX_W-1:0] REG_ENABLE        = 3'd0;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd1;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS_MS = 3'd2;
	localparam logic [IDX_W-1:0] REG_DOUBLE_MS     = 3'd3;
	localparam logic [IDX_W-1:0] REG_PRESS_IS_HIGH = 3'd4;

	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
	localparam logic [CFG_W-1:0] LONG_RST     = 16'd2000;
	localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd400;

	typedef struct packed {
		logic             enable;
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
		logic [CFG_W-1:0] double_press_ms;
		logic             press_is_high;
	} bdpc_cfg_t;

	typedef struct packed {
		logic              pin_level;
		logic [TIME_W-1:0] now_ms;
	} bdpc_sample_t;

	typedef struct packed {
		logic              pressed;
		logic              released;
		logic              long_press;
		logic              double_press;
		logic [TIME_W-1:0] hold_ms;
		logic [KIND_W-1:0] press_kind;
	} bdpc_result_t;

endpackage

// ===== src/bdpc_if.sv =====
interface bdpc_sample_if;
	logic                          valid;
	logic                          ready;
	logic                          pin_level;
	logic [bdpc_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, output pin_level, output now_ms, input ready);
	modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdpc_result_if;
	logic                          valid;
	logic                          ready;
	logic                          pressed;
	logic                          released;
	logic                          long_press;
	logic                          double_press;
	logic [bdpc_pkg::TIME_W-1:0]   hold_ms;
	logic [bdpc_pkg::KIND_W-1:0]   press_kind;

	modport source (
		output valid, output pressed, output released, output long_press,
		output double_press, output hold_ms, output press_kind, input ready
	);
	modport sink (
		input valid, input pressed, input released, input long_press,
		input double_press, input hold_ms, input press_kind, output ready
	);
endinterface

interface bdpc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [bdpc_pkg::IDX_W-1:0]  index;
	logic [bdpc_pkg::CFG_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/button_debounce_press_classifier.sv =====
// Button debounce and press classifier.
// sample: one transaction per raw pin sample, carrying pin_level and a free-running
//   millisecond stamp now_ms (wraps at 2^32).
// result: one transaction per sample with the press/release/long/double flags,
//   the current hold time and the last press kind.
// cfg: register writes (index, data), always ready; write only while the block is
//   idle. Index 0 enable, 1 debounce_ms, 2 long_press_ms, 3 double_press_ms,
//   4 press_is_high; other indices are ignored.
// An accepted sample is registered in sample_s1, processed by a single
//   combinational step and registered again in result_s2, which drives result.
// Throughput: one sample per cycle while result is not held off; when enabled,
//   the classifier state updates in the cycle a sample leaves the input register,
//   so the next sample sees it straight away.
// Reset: the levels go to the idle-high state, timers and press kind clear and
//   the registers take their defaults (disabled, 20/2000/400 ms, press is low).
// Stall: while result is held off, the finished result waits in the output
//   register and one more sample is taken into the input register; then sample
//   ready drops until the output is taken.
module button_debounce_press_classifier (
	input  logic         clk,
	input  logic         arst_n,
	bdpc_cfg_if.sink     cfg,
	bdpc_sample_if.sink  sample,
	bdpc_result_if.source result
);

	bdpc_pkg::bdpc_cfg_t     cfg_q;
	bdpc_pkg::bdpc_sample_t  sample_s1;
	bdpc_pkg::bdpc_result_t  step_res, result_s2;
	logic                    valid_s1, valid_s2;
	logic                    take, adv_s1;

	assign take         = !valid_s2 || result.ready;
	assign adv_s1       = valid_s1 && take;
	assign sample.ready = !valid_s1 || take;

	bdpc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	bdpc_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.cfg_q     (cfg_q),
		.sample_s1 (sample_s1),
		.result    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (take) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1.pin_level <= sample.pin_level;
			sample_s1.now_ms    <= sample.now_ms;
		end
		if (adv_s1) begin
			result_s2 <= step_res;
		end
	end

	assign result.valid        = valid_s2;
	assign result.pressed      = result_s2.pressed;
	assign result.released     = result_s2.released;
	assign result.long_press   = result_s2.long_press;
	assign result.double_press = result_s2.double_press;
	assign result.hold_ms      = result_s2.hold_ms;
	assign result.press_kind   = result_s2.press_kind;

endmodule

// ===== src/bdpc_cfg_regs.sv =====
module bdpc_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	bdpc_cfg_if.sink             cfg,
	output bdpc_pkg::bdpc_cfg_t  cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b0;
			cfg_q.debounce_ms     <= bdpc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms   <= bdpc_pkg::LONG_RST;
			cfg_q.double_press_ms <= bdpc_pkg::DOUBLE_RST;
			cfg_q.press_is_high   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bdpc_pkg::REG_ENABLE:        cfg_q.enable          <= cfg.data[0];
				bdpc_pkg::REG_DEBOUNCE_MS:   cfg_q.debounce_ms     <= cfg.data;
				bdpc_pkg::REG_LONG_PRESS_MS: cfg_q.long_press_ms   <= cfg.data;
				bdpc_pkg::REG_DOUBLE_MS:     cfg_q.double_press_ms <= cfg.data;
				bdpc_pkg::REG_PRESS_IS_HIGH: cfg_q.press_is_high   <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/bdpc_step.sv =====
module bdpc_step (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  bdpc_pkg::bdpc_cfg_t     cfg_q,
	input  bdpc_pkg::bdpc_sample_t  sample_s1,
	output bdpc_pkg::bdpc_result_t  result
);

	logic                          raw_q, steady_q, prev_q;
	logic [bdpc_pkg::TIME_W-1:0]   change_q, press_q, release_q, hold_q;
	logic [bdpc_pkg::KIND_W-1:0]   kind_q;

	logic                          raw_n, steady_n, prev_n;
	logic [bdpc_pkg::TIME_W-1:0]   change_n, press_n, release_n, hold_n;
	logic [bdpc_pkg::KIND_W-1:0]   kind_n, kind_aged;
	logic [bdpc_pkg::TIME_W-1:0]   long_ext, dbl_ext, deb_ext, now;
	logic                          is_press, is_release;

	always_comb begin
		now       = sample_s1.now_ms;
		long_ext  = {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, cfg_q.long_press_ms};
		dbl_ext   = {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, cfg_q.double_press_ms};
		deb_ext   = {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, cfg_q.debounce_ms};

		kind_aged = (kind_q == bdpc_pkg::KIND_NORMAL && hold_q >= long_ext)
			? bdpc_pkg::KIND_LONG : kind_q;
		hold_n    = (press_q != '0) ? now - press_q : '0;

		raw_n     = sample_s1.pin_level;
		change_n  = (sample_s1.pin_level != raw_q) ? now : change_q;

		prev_n    = prev_q;
		steady_n  = steady_q;
		if (now - change_n >= deb_ext) begin
			prev_n   = steady_q;
			steady_n = sample_s1.pin_level;
		end

		is_press   = (prev_n != steady_n) && (steady_n == cfg_q.press_is_high);
		is_release = (prev_n != steady_n) && (steady_n != cfg_q.press_is_high);

		kind_n    = is_press ? bdpc_pkg::KIND_NORMAL : kind_aged;
		press_n   = is_press ? now : (is_release ? '0 : press_q);
		release_n = is_release ? now : release_q;

		if (cfg_q.enable) begin
			result.pressed      = is_press;
			result.released     = is_release;
			result.long_press   = kind_n == bdpc_pkg::KIND_NORMAL && hold_n >= long_ext;
			result.double_press = is_release && (now - release_q < dbl_ext);
			result.hold_ms      = hold_n;
			result.press_kind   = kind_n;
		end else begin
			result.pressed      = 1'b0;
			result.released     = 1'b0;
			result.long_press   = 1'b0;
			result.double_press = 1'b0;
			result.hold_ms      = hold_q;
			result.press_kind   = kind_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q     <= 1'b1;
			steady_q  <= 1'b1;
			prev_q    <= 1'b1;
			change_q  <= '0;
			press_q   <= '0;
			release_q <= '0;
			hold_q    <= '0;
			kind_q    <= bdpc_pkg::KIND_NONE;
		end else if (step && cfg_q.enable) begin
			raw_q     <= raw_n;
			steady_q  <= steady_n;
			prev_q    <= prev_n;
			change_q  <= change_n;
			press_q   <= press_n;
			release_q <= release_n;
			hold_q    <= hold_n;
			kind_q    <= kind_n;
		end
	end

endmodule

// ===== src/bdpc_checker.sv =====
module bdpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          r_valid,
	input logic                          r_ready,
	input logic                          r_pressed,
	input logic                          r_released,
	input logic                          r_long_press,
	input logic                          r_double_press,
	input logic [bdpc_pkg::TIME_W-1:0]   r_hold_ms,
	input logic [bdpc_pkg::KIND_W-1:0]   r_press_kind
);

	// a stalled result stays valid with hold_ms and press_kind stable
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_hold_ms) && $stable(r_press_kind))
		else $error("stalled result changed");

	a_edge_excl: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> !(r_pressed && r_released))
		else $error("press and release in one transaction");

	a_double_rel: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_double_press |-> r_released)
		else $error("double press without release");

	a_long_kind: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && (r_long_press || r_pressed) |-> r_press_kind == bdpc_pkg::KIND_NORMAL)
		else $error("press or long press with wrong kind");

	a_none_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_press_kind == bdpc_pkg::KIND_NONE |-> r_hold_ms == '0)
		else $error("hold time without any press");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.r_valid        (result.valid),
	.r_ready        (result.ready),
	.r_pressed      (result.pressed),
	.r_released     (result.released),
	.r_long_press   (result.long_press),
	.r_double_press (result.double_press),
	.r_hold_ms      (result.hold_ms),
	.r_press_kind   (result.press_kind)
);

// ===== sim/tb_button_debounce_press_classifier.sv =====
`timescale 1ns / 100ps

module tb_button_debounce_press_classifier;

	localparam int unsigned RUN_LIMIT = 1000000;

	typedef logic [bdpc_pkg::TIME_W-1:0] stamp_t;
	typedef logic [bdpc_pkg::CFG_W-1:0]  cfgval_t;

	logic clk;
	logic arst_n;

	bdpc_cfg_if    cfg_ch ();
	bdpc_sample_if smp_ch ();
	bdpc_result_if res_ch ();

	button_debounce_press_classifier u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (smp_ch),
		.result (res_ch)
	);

	bdpc_pkg::bdpc_sample_t      pending_q[$];
	bdpc_pkg::bdpc_sample_t      next_smp;
	bdpc_pkg::bdpc_result_t      press_reports_q[$];
	bdpc_pkg::bdpc_result_t      want_r;
	int unsigned                 smp_sent_n;
	int unsigned                 smp_accepted_n;
	int unsigned                 src_gap;
	int unsigned                 snk_gap;
	int unsigned                 queued_n;
	int unsigned                 cycles;
	int                          mismatches;
	logic                        src_quiet;
	logic                        snk_quiet;
	logic                        res_hold = 1'b0;
	logic [bdpc_pkg::TIME_W-1:0] stim_t;

	// classifier copy
	logic                        m_enable;
	logic [bdpc_pkg::CFG_W-1:0]  m_debounce;
	logic [bdpc_pkg::CFG_W-1:0]  m_long;
	logic [bdpc_pkg::CFG_W-1:0]  m_double;
	logic                        m_high;
	logic                        m_raw;
	logic                        m_steady;
	logic                        m_prev;
	logic [bdpc_pkg::TIME_W-1:0] m_change_t;
	logic [bdpc_pkg::TIME_W-1:0] m_press_t;
	logic [bdpc_pkg::TIME_W-1:0] m_release_t;
	logic [bdpc_pkg::TIME_W-1:0] m_hold;
	logic [bdpc_pkg::KIND_W-1:0] m_kind;

	always #2 clk = ~clk;

	function automatic bdpc_pkg::bdpc_result_t classify_sample(logic pin,
			logic [bdpc_pkg::TIME_W-1:0] now);
		bdpc_pkg::bdpc_result_t r;
		logic                   is_press;
		logic                   is_rel;
		r = '0;
		if (m_enable) begin
			if (m_kind == bdpc_pkg::KIND_NORMAL && m_hold >= m_long)
				m_kind = bdpc_pkg::KIND_LONG;
			m_hold = (m_press_t != '0) ? now - m_press_t : '0;
			if (pin != m_raw) begin
				m_change_t = now;
				m_raw      = pin;
			end
			if (now - m_change_t >= m_debounce) begin
				m_prev   = m_steady;
				m_steady = pin;
			end
			is_press = m_high ? (!m_prev && m_steady) : (m_prev && !m_steady);
			is_rel   = m_high ? (m_prev && !m_steady) : (!m_prev && m_steady);
			if (is_press) begin
				m_kind     = bdpc_pkg::KIND_NORMAL;
				m_press_t  = now;
				r.pressed  = 1'b1;
			end
			if (is_rel) begin
				m_press_t      = '0;
				r.double_press = (now - m_release_t) < m_double;
				m_release_t    = now;
				r.released     = 1'b1;
			end
			r.long_press = (m_kind == bdpc_pkg::KIND_NORMAL && m_hold >= m_long);
		end
		r.hold_ms    = m_hold;
		r.press_kind = m_kind;
		return r;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic check_field(string name, stamp_t want, stamp_t got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic push_sample(logic pin, int unsigned dt);
		stim_t += dt;
		pending_q.push_back('{pin_level: pin, now_ms: stim_t});
		queued_n++;
	endtask

	task automatic add_at(logic pin, logic [bdpc_pkg::TIME_W-1:0] t);
		stim_t = t;
		push_sample(pin, 0);
	endtask

	task automatic queue_gesture();
		logic        act;
		int unsigned db;
		int unsigned span;
		int unsigned n;
		act = m_high;
		db  = 32'(m_debounce);
		n   = $urandom_range(0, 4);
		repeat (n) push_sample(1'($urandom_range(0, 1)), $urandom_range(0, db / 2 + 1));
		push_sample(act, $urandom_range(0, db / 2 + 1));
		span = $urandom_range(0, 2 * m_long + 2 * db + 20);
		n    = $urandom_range(1, 10);
		repeat (n) push_sample(act, span / n + $urandom_range(0, 2));
		n = $urandom_range(0, 4);
		repeat (n) push_sample(1'($urandom_range(0, 1)), $urandom_range(0, db / 2 + 1));
		span = $urandom_range(0, db + m_double + 10);
		n    = $urandom_range(1, 6);
		repeat (n) push_sample(!act, span / n + $urandom_range(0, 2));
	endtask

	task automatic queue_noise();
		int unsigned n = $urandom_range(1, 5);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				stim_t = $urandom();
			push_sample(1'($urandom_range(0, 1)), $urandom_range(0, m_debounce + 5));
		end
	endtask

	task automatic write_reg(logic [bdpc_pkg::IDX_W-1:0] idx, logic [bdpc_pkg::CFG_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			bdpc_pkg::REG_ENABLE:        m_enable   = d[0];
			bdpc_pkg::REG_DEBOUNCE_MS:   m_debounce = d;
			bdpc_pkg::REG_LONG_PRESS_MS: m_long     = d;
			bdpc_pkg::REG_DOUBLE_MS:     m_double   = d;
			bdpc_pkg::REG_PRESS_IS_HIGH: m_high     = d[0];
			default: ;
		endcase
	endtask

	task automatic program_regs(logic en, int unsigned deb, int unsigned lp,
			int unsigned dbl, logic hi);
		logic [bdpc_pkg::CFG_W-1:0] d;
		d    = cfgval_t'($urandom());
		d[0] = en;
		write_reg(bdpc_pkg::REG_ENABLE, d);
		write_reg(bdpc_pkg::REG_DEBOUNCE_MS, cfgval_t'(deb));
		write_reg(bdpc_pkg::REG_LONG_PRESS_MS, cfgval_t'(lp));
		write_reg(bdpc_pkg::REG_DOUBLE_MS, cfgval_t'(dbl));
		d    = cfgval_t'($urandom());
		d[0] = hi;
		write_reg(bdpc_pkg::REG_PRESS_IS_HIGH, d);
		for (int i = bdpc_pkg::REG_PRESS_IS_HIGH + 1; i < (1 << bdpc_pkg::IDX_W); i++)
			write_reg(i[bdpc_pkg::IDX_W-1:0], cfgval_t'($urandom()));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() != 0 || smp_ch.valid || press_reports_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(logic en, int unsigned deb, int unsigned lp, int unsigned dbl,
			logic hi, int unsigned n_items, logic quiet_src, logic quiet_snk);
		program_regs(en, deb, lp, dbl, hi);
		@(posedge clk);
		src_quiet = quiet_src;
		snk_quiet = quiet_snk;
		queued_n  = 0;
		while (queued_n < n_items) begin
			if ($urandom_range(0, 9) < 8)
				queue_gesture();
			else
				queue_noise();
		end
		drain();
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		smp_ch.valid    = 1'b0;
		smp_ch.pin_level = 1'b0;
		smp_ch.now_ms   = '0;
		res_ch.ready    = 1'b0;
		smp_sent_n      = 0;
		smp_accepted_n  = 0;
		src_gap         = 0;
		snk_gap         = 0;
		cycles          = 0;
		mismatches      = 0;
		src_quiet       = 1'b0;
		snk_quiet       = 1'b0;
		stim_t          = '0;
		m_enable        = 1'b0;
		m_debounce      = bdpc_pkg::DEBOUNCE_RST;
		m_long          = bdpc_pkg::LONG_RST;
		m_double        = bdpc_pkg::DOUBLE_RST;
		m_high          = 1'b0;
		m_raw           = 1'b1;
		m_steady        = 1'b1;
		m_prev          = 1'b1;
		m_change_t      = '0;
		m_press_t       = '0;
		m_release_t     = '0;
		m_hold          = '0;
		m_kind          = bdpc_pkg::KIND_NONE;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// disabled after reset: state frozen
		add_at(1'b0, 32'h0000_0064);
		add_at(1'b1, 32'hFFFF_FFFF);
		add_at(1'b0, 32'h0000_0000);
		drain();

		program_regs(1'b1, 32'(bdpc_pkg::DEBOUNCE_RST), 100,
			32'(bdpc_pkg::DOUBLE_RST), 1'b0);
		// press at time zero across the wrap, then a quick release
		add_at(1'b0, 32'hFFFF_FFEC);
		add_at(1'b0, 32'd0);
		add_at(1'b0, 32'd50);
		add_at(1'b1, 32'd60);
		add_at(1'b1, 32'd80);
		// long press while held
		add_at(1'b0, 32'd100);
		add_at(1'b0, 32'd120);
		add_at(1'b0, 32'd200);
		add_at(1'b0, 32'd230);
		add_at(1'b1, 32'd300);
		add_at(1'b1, 32'd320);
		// long press reached on the release step
		add_at(1'b0, 32'd400);
		add_at(1'b0, 32'd420);
		add_at(1'b0, 32'd500);
		add_at(1'b1, 32'd510);
		add_at(1'b1, 32'd530);
		// bouncing raw level keeps the edge visible
		add_at(1'b0, 32'd600);
		add_at(1'b0, 32'd620);
		add_at(1'b1, 32'd625);
		add_at(1'b0, 32'd630);
		add_at(1'b1, 32'd1200);
		add_at(1'b1, 32'd1220);
		drain();

		run_phase(1'b1, 5, 60, 80, 1'b0, 250, 1'b0, 1'b0);
		run_phase(1'b1, 0, 0, 0, 1'b1, 150, 1'b1, 1'b0);
		run_phase(1'b1, 65535, 65535, 65535, 1'b0, 100, 1'b0, 1'b1);
		run_phase(1'b1, $urandom_range(0, 40), $urandom_range(0, 400),
			$urandom_range(0, 500), 1'($urandom_range(0, 1)), 250, 1'b0, 1'b0);
		run_phase(1'b0, $urandom_range(0, 40), $urandom_range(0, 400),
			$urandom_range(0, 500), 1'($urandom_range(0, 1)), 60, 1'b0, 1'b0);
		run_phase(1'b1, $urandom_range(0, 30), $urandom_range(0, 300),
			$urandom_range(0, 400), 1'b1, 300, 1'b1, 1'b1);
		run_phase(1'b1, 32'(bdpc_pkg::DEBOUNCE_RST), 32'(bdpc_pkg::LONG_RST),
			32'(bdpc_pkg::DOUBLE_RST), 1'b0, 200, 1'b0, 1'b0);

		repeat (8) @(posedge clk);
		if (mismatches == 0 && press_reports_q.size() == 0)
			$display("** button_debounce_press_classifier: PASSED **");
		else
			$display("** button_debounce_press_classifier: FAILED **");
		$finish;
	end

	// long receiver hold-off so the block fills and stalls its input
	initial begin
		wait (smp_accepted_n >= 400);
		@(negedge clk);
		res_hold <= 1'b1;
		repeat (300) @(negedge clk);
		res_hold <= 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			smp_ch.valid <= 1'b0;
		end else if (smp_ch.valid && smp_sent_n != smp_accepted_n) begin
		end else if (src_gap != 0) begin
			smp_ch.valid <= 1'b0;
			src_gap      <= src_gap - 1;
		end else if (pending_q.size() != 0) begin
			next_smp = pending_q.pop_front();
			smp_ch.valid     <= 1'b1;
			smp_ch.pin_level <= next_smp.pin_level;
			smp_ch.now_ms    <= next_smp.now_ms;
			smp_sent_n       <= smp_sent_n + 1;
			src_gap          <= src_quiet ? 0 : idle_len();
		end else begin
			smp_ch.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n || res_hold) begin
			res_ch.ready <= 1'b0;
		end else if (snk_gap != 0) begin
			res_ch.ready <= 1'b0;
			snk_gap      <= snk_gap - 1;
		end else begin
			res_ch.ready <= 1'b1;
			snk_gap      <= snk_quiet ? 0 : idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && smp_ch.valid && smp_ch.ready) begin
			press_reports_q.push_back(classify_sample(smp_ch.pin_level, smp_ch.now_ms));
			smp_accepted_n <= smp_accepted_n + 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (press_reports_q.size() == 0) begin
				$error("result transaction with no sample outstanding");
				mismatches++;
			end else begin
				want_r = press_reports_q.pop_front();
				check_field("pressed", stamp_t'(want_r.pressed), stamp_t'(res_ch.pressed));
				check_field("released", stamp_t'(want_r.released),
					stamp_t'(res_ch.released));
				check_field("long_press", stamp_t'(want_r.long_press),
					stamp_t'(res_ch.long_press));
				check_field("double_press", stamp_t'(want_r.double_press),
					stamp_t'(res_ch.double_press));
				check_field("hold_ms", want_r.hold_ms, res_ch.hold_ms);
				check_field("press_kind", stamp_t'(want_r.press_kind),
					stamp_t'(res_ch.press_kind));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("** button_debounce_press_classifier: FAILED **");
			$finish;
		end
	end

endmodule
